### hw/rtl/tcw_pkg.sv
package tcw_pkg;

	typedef enum logic [1:0] {
		KIND_PUT   = 2'd0,
		KIND_CLEAR = 2'd1,
		KIND_READ  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_BACKSPACE = 8'h08;
	localparam logic [7:0] RESET_COLOR  = 8'h07;

endpackage

### hw/rtl/text_console_writer_top.sv
// Results: a printed character, newline, backspace within a row or at home, an unused kind or a
// read past the last cell gives its registered result in the cycle after the transaction; a read
// of a cell on the screen first passes the read state to take the registered memory output; a
// backspace to the previous row waits for the row scan; a clear waits for a pass over every cell.
// Flow: s_tready is low while an item is in work or its result is still waiting, so a new item is
// taken only after the last result has gone; the cell memory paces the scan and the clear.
// Reset: the cursor homes, text_color becomes 7, and a clearing pass over every cell fills the
// cell memory with 0x0720 while s_tready stays low.
module text_console_writer_top
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // char_code [7:0], cell_index [18:8], zero fill
	input  logic [1:0]  s_tuser,   // kind [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// cursor_column [6:0], cursor_row [11:7], cursor_index [22:12], written_index [33:23],
	// written_entry [49:34], read_entry [65:50], zero fill
	output logic [71:0] m_tdata,
	output logic [0:0]  m_tuser,   // cell_written [0]
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int COL_W = $clog2(COLUMNS);
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int IDX_W = $clog2(CELLS);
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
	localparam logic [COL_W-1:0] COL_PEN  = COL_W'(COLUMNS - 2);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CELLS - 1);
	localparam logic [IDX_W-1:0] IDX_ROW  = IDX_W'(COLUMNS);

	typedef enum logic [4:0] {
		ST_INIT  = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_CLEAR = 5'b00100,
		ST_SCAN  = 5'b01000,
		ST_READ  = 5'b10000
	} state_t;

	state_t            state_q;
	logic [7:0]        text_color_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  clr_q;
	logic [IDX_W-1:0]  base_q;
	logic [COL_W-1:0]  scan_col_q;
	logic              issue_q;
	logic              rd_s1;
	logic [COL_W-1:0]  colp_s1;

	logic              out_valid_q;
	logic [6:0]        out_col_q;
	logic [4:0]        out_row_q;
	logic [10:0]       out_idx_q;
	logic              out_written_q;
	logic [10:0]       out_widx_q;
	logic [15:0]       out_wentry_q;
	logic [15:0]       out_rentry_q;

	kind_t             kind;
	logic [7:0]        char_code;
	logic [10:0]       cell_index;
	logic              accept;
	logic              read_in_range;
	logic              scan_hit;
	logic [COL_W-1:0]  new_col;
	logic [COL_W-1:0]  add_col;
	logic [IDX_W-1:0]  add_sum;

	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [15:0]       mem_wdata;
	logic [IDX_W-1:0]  mem_raddr;
	logic [15:0]       mem_rdata;

	assign kind       = kind_t'(s_tuser);
	assign char_code  = s_tdata[7:0];
	assign cell_index = s_tdata[18:8];
	assign s_tready   = (state_q == ST_IDLE) && !out_valid_q;
	assign accept     = s_tvalid && s_tready;
	assign read_in_range = 32'(cell_index) < 32'(CELLS);

	// The row scan ends at the first non-space cell from the right, or at column zero.
	assign scan_hit = (state_q == ST_SCAN) && rd_s1
		&& ((mem_rdata[7:0] != CH_SPACE) || (colp_s1 == '0));

	always_comb begin
		if (mem_rdata[7:0] == CH_SPACE) begin
			new_col = '0;
		end else if (colp_s1 >= COL_PEN) begin
			new_col = COL_LAST;
		end else begin
			new_col = colp_s1;
		end
	end

	// One adder forms every row-relative address: scan reads and the final blanking write.
	assign add_col = scan_hit ? new_col : scan_col_q;
	assign add_sum = base_q + IDX_W'(add_col);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = {text_color_q, CH_SPACE};
		mem_raddr = add_sum;
		unique case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = {RESET_COLOR, CH_SPACE};
			end
			ST_IDLE: begin
				mem_raddr = IDX_W'(cell_index);
				if (accept && (kind == KIND_PUT) && (char_code != CH_NEWLINE)) begin
					mem_we = 1'b1;
					if (char_code == CH_BACKSPACE) begin
						if (col_q != '0) begin
							mem_waddr = idx_q - IDX_W'(1);
						end else if (row_q != '0) begin
							mem_we = 1'b0;
						end
					end else begin
						mem_wdata = {text_color_q, char_code};
					end
				end
			end
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			ST_SCAN: begin
				if (scan_hit) begin
					mem_we    = 1'b1;
					mem_waddr = add_sum;
				end
			end
			ST_READ: begin
			end
			default: begin
			end
		endcase
	end

	tcw_ram #(
		.WIDTH (16),
		.DEPTH (CELLS)
	) u_cell_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_INIT;
			text_color_q  <= RESET_COLOR;
			col_q         <= '0;
			row_q         <= '0;
			idx_q         <= '0;
			clr_q         <= '0;
			base_q        <= '0;
			scan_col_q    <= '0;
			issue_q       <= 1'b0;
			rd_s1         <= 1'b0;
			colp_s1       <= '0;
			out_valid_q   <= 1'b0;
			out_col_q     <= '0;
			out_row_q     <= '0;
			out_idx_q     <= '0;
			out_written_q <= 1'b0;
			out_widx_q    <= '0;
			out_wentry_q  <= '0;
			out_rentry_q  <= '0;
		end else begin
			if (cfg_we) begin
				text_color_q <= cfg_wdata;
			end
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_INIT: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_LAST) begin
						clr_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						out_written_q <= 1'b0;
						out_widx_q    <= '0;
						out_wentry_q  <= '0;
						out_rentry_q  <= '0;
						out_col_q     <= 7'(col_q);
						out_row_q     <= 5'(row_q);
						out_idx_q     <= 11'(idx_q);
						unique case (kind)
							KIND_PUT: begin
								if (char_code == CH_NEWLINE) begin
									out_valid_q <= 1'b1;
									col_q       <= '0;
									out_col_q   <= '0;
									if (row_q == ROW_LAST) begin
										row_q     <= '0;
										idx_q     <= '0;
										out_row_q <= '0;
										out_idx_q <= '0;
									end else begin
										row_q     <= row_q + ROW_W'(1);
										idx_q     <= idx_q + IDX_ROW - IDX_W'(col_q);
										out_row_q <= 5'(row_q + ROW_W'(1));
										out_idx_q <= 11'(idx_q + IDX_ROW - IDX_W'(col_q));
									end
								end else if (char_code == CH_BACKSPACE) begin
									if (col_q != '0) begin
										out_valid_q   <= 1'b1;
										col_q         <= col_q - COL_W'(1);
										idx_q         <= idx_q - IDX_W'(1);
										out_col_q     <= 7'(col_q - COL_W'(1));
										out_idx_q     <= 11'(idx_q - IDX_W'(1));
										out_written_q <= 1'b1;
										out_widx_q    <= 11'(idx_q - IDX_W'(1));
										out_wentry_q  <= {text_color_q, CH_SPACE};
									end else if (row_q == '0) begin
										out_valid_q   <= 1'b1;
										out_written_q <= 1'b1;
										out_widx_q    <= 11'(idx_q);
										out_wentry_q  <= {text_color_q, CH_SPACE};
									end else begin
										row_q      <= row_q - ROW_W'(1);
										base_q     <= idx_q - IDX_ROW;
										scan_col_q <= COL_LAST;
										issue_q    <= 1'b1;
										rd_s1      <= 1'b0;
										state_q    <= ST_SCAN;
									end
								end else begin
									out_valid_q   <= 1'b1;
									out_written_q <= 1'b1;
									out_widx_q    <= 11'(idx_q);
									out_wentry_q  <= {text_color_q, char_code};
									if (col_q == COL_LAST) begin
										col_q     <= '0;
										out_col_q <= '0;
										if (row_q == ROW_LAST) begin
											row_q     <= '0;
											idx_q     <= '0;
											out_row_q <= '0;
											out_idx_q <= '0;
										end else begin
											row_q     <= row_q + ROW_W'(1);
											idx_q     <= idx_q + IDX_W'(1);
											out_row_q <= 5'(row_q + ROW_W'(1));
											out_idx_q <= 11'(idx_q + IDX_W'(1));
										end
									end else begin
										col_q     <= col_q + COL_W'(1);
										idx_q     <= idx_q + IDX_W'(1);
										out_col_q <= 7'(col_q + COL_W'(1));
										out_idx_q <= 11'(idx_q + IDX_W'(1));
									end
								end
							end
							KIND_CLEAR: begin
								col_q   <= '0;
								row_q   <= '0;
								idx_q   <= '0;
								clr_q   <= '0;
								state_q <= ST_CLEAR;
							end
							KIND_READ: begin
								if (read_in_range) begin
									state_q <= ST_READ;
								end else begin
									out_valid_q <= 1'b1;
								end
							end
							KIND_NONE: begin
								out_valid_q <= 1'b1;
							end
							default: begin
								out_valid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_LAST) begin
						clr_q       <= '0;
						out_valid_q <= 1'b1;
						out_col_q   <= '0;
						out_row_q   <= '0;
						out_idx_q   <= '0;
						state_q     <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (scan_hit) begin
						rd_s1         <= 1'b0;
						issue_q       <= 1'b0;
						col_q         <= new_col;
						idx_q         <= add_sum;
						out_valid_q   <= 1'b1;
						out_col_q     <= 7'(new_col);
						out_row_q     <= 5'(row_q);
						out_idx_q     <= 11'(add_sum);
						out_written_q <= 1'b1;
						out_widx_q    <= 11'(add_sum);
						out_wentry_q  <= {text_color_q, CH_SPACE};
						state_q       <= ST_IDLE;
					end else begin
						rd_s1   <= issue_q;
						colp_s1 <= scan_col_q;
						if (issue_q) begin
							if (scan_col_q == '0) begin
								issue_q <= 1'b0;
							end else begin
								scan_col_q <= scan_col_q - COL_W'(1);
							end
						end
					end
				end
				ST_READ: begin
					out_valid_q  <= 1'b1;
					out_rentry_q <= mem_rdata;
					state_q      <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_written_q;
	assign m_tdata  = {6'd0, out_rentry_q, out_wentry_q, out_widx_q, out_idx_q,
		out_row_q, out_col_q};

	// The linear cursor index is kept in step with the row and column between items.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (32'(idx_q) == 32'(row_q) * COLUMNS + 32'(col_q)))
		else $error("cursor index out of step with row and column");

	assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= COL_LAST) && (row_q <= ROW_LAST))
		else $error("cursor outside the screen");

	// During the row scan the base address points at the start of the new cursor row.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (32'(base_q) == 32'(row_q) * COLUMNS))
		else $error("scan base does not match the cursor row");

endmodule

### hw/rtl/tcw_ram.sv
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
